@@ hw/rtl/bfa_pkg.sv @@
`default_nettype none

package bfa_pkg;

	// Operation codes carried by the operation port.
	localparam logic [1:0] OP_ALLOCATE = 2'd0;
	localparam logic [1:0] OP_RELEASE  = 2'd1;
	localparam logic [1:0] OP_RESTART  = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_NO_FIT = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	// Control from the sequencer to the best-fit tracker.
	typedef struct packed {
		logic clear;
		logic sample;
	} track_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/bfa_best_track.sv @@
`default_nettype none

module bfa_best_track #(
	parameter int SIZE_BITS = 16,
	parameter int IDX_BITS  = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bfa_pkg::track_ctl_t  ctl,
	input  wire logic [SIZE_BITS-1:0] data,
	input  wire logic [IDX_BITS-1:0]  index,
	input  wire logic [SIZE_BITS-1:0] want,
	output logic                      found,
	output logic [SIZE_BITS-1:0]      best_size,
	output logic [IDX_BITS-1:0]       best_idx
);

	logic                 found_q;
	logic [SIZE_BITS-1:0] best_size_q;
	logic [IDX_BITS-1:0]  best_idx_q;
	logic                 take;

	// A strictly smaller size is needed to replace the current best, so the
	// entry nearest the front wins a tie.
	assign take = ctl.sample && (data >= want) && (!found_q || (data < best_size_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_size_q <= data;
			best_idx_q  <= index;
		end
	end

	assign found     = found_q;
	assign best_size = best_size_q;
	assign best_idx  = best_idx_q;

endmodule

`default_nettype wire

@@ hw/rtl/best_fit_free_list_allocator.sv @@
`default_nettype none

// Best-fit allocator over a list of free block sizes kept in a memory with
// one read port and one write port, newest entry at the front. An item is
// taken when start is high and busy is low; its one result appears on status
// and granted_size for exactly one cycle with done high, and the receiver
// cannot stall it. Restart, an unused code, an allocate on an empty list and
// a release on a full list finish at once: done rises in the cycle after the
// accepting edge. A release keeps busy high while the list moves back by one
// entry to make room for the new block at the front. An allocate keeps busy
// high to scan every entry through the one comparator, which is all it does
// when no block fits. When entry B is taken, the entries behind it move one
// place forward to close the gap. The memory's one read and one write per
// cycle pace these steps.
module best_fit_free_list_allocator #(
	parameter int POOL_ENTRIES = 16,
	parameter int SIZE_BITS    = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  operation,
	input  wire logic [15:0] request_size,
	output logic             done,
	output logic [1:0]       status,
	output logic [15:0]      granted_size
);

	localparam int IDX_BITS = $clog2(POOL_ENTRIES);
	localparam int CNT_BITS = $clog2(POOL_ENTRIES + 1);
	localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(POOL_ENTRIES);

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_SCAN    = 4'b0010,
		S_COMPACT = 4'b0100,
		S_SHIFT   = 4'b1000
	} state_t;

	state_t                state_q, state_d;
	logic [CNT_BITS-1:0]   count_q, count_d;
	logic [CNT_BITS-1:0]   rd_q, rd_d, rd_dec;
	logic                  pend_s1, pend_d;
	logic [IDX_BITS-1:0]   pidx_s1, pidx_d;
	logic [SIZE_BITS-1:0]  want_q, want_d, req_w;
	logic                  done_q, done_d;
	logic [1:0]            status_q, status_d;
	logic [15:0]           granted_q, granted_d;

	logic [SIZE_BITS-1:0]  mem [POOL_ENTRIES];
	logic [SIZE_BITS-1:0]  rd_data_q;
	logic [IDX_BITS-1:0]   rd_addr;
	logic                  we;
	logic [IDX_BITS-1:0]   wa;
	logic [SIZE_BITS-1:0]  wd;

	bfa_pkg::track_ctl_t   ctl;
	logic                  found;
	logic [SIZE_BITS-1:0]  best_size;
	logic [IDX_BITS-1:0]   best_idx;

	assign req_w  = SIZE_BITS'(request_size);
	assign rd_dec = rd_q - CNT_BITS'(1);

	bfa_best_track #(
		.SIZE_BITS (SIZE_BITS),
		.IDX_BITS  (IDX_BITS)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.data      (rd_data_q),
		.index     (pidx_s1),
		.want      (want_q),
		.found     (found),
		.best_size (best_size),
		.best_idx  (best_idx)
	);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		rd_d      = rd_q;
		pend_d    = 1'b0;
		pidx_d    = pidx_s1;
		want_d    = want_q;
		done_d    = 1'b0;
		status_d  = status_q;
		granted_d = granted_q;
		rd_addr   = '0;
		we        = 1'b0;
		wa        = '0;
		wd        = want_q;
		ctl       = '0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					want_d    = req_w;
					granted_d = '0;
					case (operation)
						bfa_pkg::OP_ALLOCATE: begin
							if (count_q == '0) begin
								done_d   = 1'b1;
								status_d = bfa_pkg::ST_EMPTY;
							end else begin
								state_d   = S_SCAN;
								rd_d      = '0;
								ctl.clear = 1'b1;
							end
						end
						bfa_pkg::OP_RELEASE: begin
							if (count_q == FULL_COUNT) begin
								done_d   = 1'b1;
								status_d = bfa_pkg::ST_FULL;
							end else begin
								state_d = S_SHIFT;
								rd_d    = count_q;
							end
						end
						bfa_pkg::OP_RESTART: begin
							we       = 1'b1;
							wa       = '0;
							wd       = req_w;
							count_d  = CNT_BITS'(1);
							done_d   = 1'b1;
							status_d = bfa_pkg::ST_OK;
						end
						default: begin
							done_d   = 1'b1;
							status_d = bfa_pkg::ST_OK;
						end
					endcase
				end
			end
			S_SCAN: begin
				// Read address goes out in the cycle before its compare.
				if (rd_q < count_q) begin
					rd_addr = rd_q[IDX_BITS-1:0];
					rd_d    = rd_q + CNT_BITS'(1);
					pend_d  = 1'b1;
					pidx_d  = rd_q[IDX_BITS-1:0];
				end
				ctl.sample = pend_s1;
				if (rd_q >= count_q && !pend_s1) begin
					if (!found) begin
						state_d  = S_IDLE;
						done_d   = 1'b1;
						status_d = bfa_pkg::ST_NO_FIT;
					end else begin
						state_d = S_COMPACT;
						rd_d    = CNT_BITS'(best_idx) + CNT_BITS'(1);
					end
				end
			end
			S_COMPACT: begin
				// Each entry behind the chosen one moves one place forward.
				if (rd_q < count_q) begin
					rd_addr = rd_q[IDX_BITS-1:0];
					rd_d    = rd_q + CNT_BITS'(1);
					pend_d  = 1'b1;
					pidx_d  = rd_q[IDX_BITS-1:0];
				end
				if (pend_s1) begin
					we = 1'b1;
					wa = pidx_s1 - IDX_BITS'(1);
					wd = rd_data_q;
				end
				if (rd_q >= count_q && !pend_s1) begin
					state_d   = S_IDLE;
					count_d   = count_q - CNT_BITS'(1);
					done_d    = 1'b1;
					status_d  = bfa_pkg::ST_OK;
					granted_d = 16'(best_size);
				end
			end
			S_SHIFT: begin
				// Walk from the back so no entry is overwritten before it moves.
				if (rd_q != '0) begin
					rd_addr = rd_dec[IDX_BITS-1:0];
					rd_d    = rd_dec;
					pend_d  = 1'b1;
					pidx_d  = rd_dec[IDX_BITS-1:0];
				end
				if (pend_s1) begin
					we = 1'b1;
					wa = pidx_s1 + IDX_BITS'(1);
					wd = rd_data_q;
				end
				if (rd_q == '0 && !pend_s1) begin
					we       = 1'b1;
					wa       = '0;
					wd       = want_q;
					state_d  = S_IDLE;
					count_d  = count_q + CNT_BITS'(1);
					done_d   = 1'b1;
					status_d = bfa_pkg::ST_OK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_s1 <= pend_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_q      <= rd_d;
		pidx_s1   <= pidx_d;
		want_q    <= want_d;
		status_q  <= status_d;
		granted_q <= granted_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign granted_size = granted_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while the sequencer is still working");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("free list length beyond capacity");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == bfa_pkg::ST_FULL) |-> (count_q == FULL_COUNT))
		else $error("list full reported on a list with room");

	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q != S_IDLE))
		else $error("memory read pending after the sequencer went idle");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam int LIST_DEPTH = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 600;
	localparam int DRAIN_CYCLES = 60;
	// The package names no code for the fourth operation; the block ignores it.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  status;
		logic [15:0] granted;
	} outcome_t;

	class best_fit_list;
		logic [15:0] sizes [LIST_DEPTH];
		int          count;
		outcome_t    owed_results [$];
		int          errors;

		function new();
			count = 0;
			errors = 0;
		endfunction

		// Applies one accepted beat to the shadow list and queues its outcome.
		function void take_request(logic [1:0] op, logic [15:0] size);
			outcome_t r;
			int       best;
			bit       found;
			r.status = bfa_pkg::ST_OK;
			r.granted = '0;
			case (op)
				bfa_pkg::OP_ALLOCATE: begin
					if (count == 0) begin
						r.status = bfa_pkg::ST_EMPTY;
					end else begin
						found = 1'b0;
						best = 0;
						for (int i = 0; i < count; i++) begin
							if (sizes[i] >= size && (!found || sizes[i] < sizes[best])) begin
								best = i;
								found = 1'b1;
							end
						end
						if (!found) begin
							r.status = bfa_pkg::ST_NO_FIT;
						end else begin
							r.granted = sizes[best];
							for (int i = best; i < count - 1; i++)
								sizes[i] = sizes[i + 1];
							count--;
						end
					end
				end
				bfa_pkg::OP_RELEASE: begin
					if (count >= LIST_DEPTH) begin
						r.status = bfa_pkg::ST_FULL;
					end else begin
						for (int i = count; i > 0; i--)
							sizes[i] = sizes[i - 1];
						sizes[0] = size;
						count++;
					end
				end
				bfa_pkg::OP_RESTART: begin
					sizes[0] = size;
					count = 1;
				end
				default: ;
			endcase
			owed_results.push_back(r);
		endfunction

		function void check_result(logic [1:0] status, logic [15:0] granted);
			outcome_t e;
			if (owed_results.size() == 0) begin
				$error("unexpected result: status %0d, granted_size %0h", status, granted);
				errors++;
				return;
			end
			e = owed_results.pop_front();
			if (status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, status);
				errors++;
			end
			if (granted !== e.granted) begin
				$error("granted_size: expected %0h, actual %0h", e.granted, granted);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  operation = bfa_pkg::OP_ALLOCATE;
	logic [15:0] request_size = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [15:0] granted_size;

	best_fit_list pool;
	int           cycle_count = 0;

	best_fit_free_list_allocator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.request_size (request_size),
		.done         (done),
		.status       (status),
		.granted_size (granted_size)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			pool.check_result(status, granted_size);
	end

	// Called at a rising edge. With no gap, start stays high straight from the
	// previous accepted beat.
	task automatic issue(input logic [1:0] op, input logic [15:0] size, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		request_size <= size;
		@(posedge clk);
		while (busy) @(posedge clk);
		pool.take_request(op, size);
	endtask

	function automatic logic [15:0] pick_size();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			// A coarse grid of sizes makes ties and exact fits common.
			2, 3, 4: return 16'($urandom_range(1, 8) * 1000);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [1:0] pick_op(bit grow);
		int r;
		r = $urandom_range(0, 99);
		if (r < (grow ? 60 : 30))
			return bfa_pkg::OP_RELEASE;
		if (r < 92)
			return bfa_pkg::OP_ALLOCATE;
		if (r < 96)
			return bfa_pkg::OP_RESTART;
		return OP_UNUSED;
	endfunction

	initial begin
		bit grow;
		bit steady;
		pool = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(bfa_pkg::OP_ALLOCATE, 16'h0000, 0);
		issue(OP_UNUSED, 16'hFFFF, 1);
		issue(bfa_pkg::OP_RESTART, 16'h8000, 0);
		issue(bfa_pkg::OP_ALLOCATE, 16'h8001, 2);
		issue(bfa_pkg::OP_ALLOCATE, 16'h0000, 0);
		issue(bfa_pkg::OP_RELEASE, 16'hFFFF, 0);
		issue(bfa_pkg::OP_RELEASE, 16'h0000, 3);
		for (int i = 0; i < 14; i++)
			issue(bfa_pkg::OP_RELEASE, 16'((i % 3) * 100 + 100), i % 2);
		// The list now holds sixteen blocks, so this release is dropped.
		issue(bfa_pkg::OP_RELEASE, 16'h1234, 0);
		issue(bfa_pkg::OP_ALLOCATE, 16'hFFFF, 0);
		issue(bfa_pkg::OP_ALLOCATE, 16'h0000, 1);
		issue(bfa_pkg::OP_ALLOCATE, 16'd150, 0);

		grow = 1'b1;
		steady = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0) begin
				grow = $urandom_range(0, 1);
				steady = ($urandom_range(0, 3) == 0);
			end
			issue(pick_op(grow), pick_size(), steady ? 0 : $urandom_range(0, 5));
		end
		start <= 1'b0;

		while (pool.owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pool.errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
